FILE: hw/rtl/q32_pkg.sv
// shared types and constants for the q32.32 arithmetic unit
`default_nettype none
package q32_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned FuncW = 3;
  localparam logic [DataW-1:0] OvfCode = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] QMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] QMin = 64'h8000_0000_0000_0000;
  localparam logic [31:0] HalfLsb = 32'h8000_0000;
  // long division steps, bit 96 down to bit 0
  localparam int unsigned DivSteps = 97;
  localparam int unsigned StepW = 7;

  localparam logic [FuncW-1:0] FuncAdd = 3'd0;
  localparam logic [FuncW-1:0] FuncSub = 3'd1;
  localparam logic [FuncW-1:0] FuncSatAdd = 3'd2;
  localparam logic [FuncW-1:0] FuncSatSub = 3'd3;
  localparam logic [FuncW-1:0] FuncMul = 3'd4;
  localparam logic [FuncW-1:0] FuncSatMul = 3'd5;
  localparam logic [FuncW-1:0] FuncDiv = 3'd6;
  localparam logic [FuncW-1:0] FuncSatDiv = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul_step;  // advance multiply sequence
    logic div_step;  // one long division step
    logic finish;    // form result
  } q32_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_zero;
    logic div_last;
    logic mul_last;
  } q32_stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/q32_if.sv
// valid/ready channels for operation items and result items
`default_nettype none
interface q32_req_if;
  import q32_pkg::*;
  logic valid;
  logic ready;
  logic [FuncW-1:0] func;
  logic signed [DataW-1:0] operand_a;
  logic signed [DataW-1:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface q32_rsp_if;
  import q32_pkg::*;
  logic valid;
  logic ready;
  logic signed [DataW-1:0] result;
  logic overflow;
  modport source (output valid, result, overflow, input ready);
  modport sink (input valid, result, overflow, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/q32_ctrl.sv
// sequencing state machine for the q32.32 arithmetic unit
`default_nettype none
module q32_ctrl import q32_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire q32_stat_t stat_i,
  output q32_cmd_t       cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StDecode, StMul, StDiv, StFinish, StOut
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  // commands follow the state
  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && (state_q == StIdle);
    cmd_o.mul_step = (state_q == StMul);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.finish = (state_q == StFinish);
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StDecode;
        end
        StDecode: begin
          if (stat_i.is_mul) state_q <= StMul;
          else if (stat_i.is_div && !stat_i.div_zero) state_q <= StDiv;
          else state_q <= StFinish;
        end
        StMul: begin
          if (stat_i.mul_last) state_q <= StFinish;
        end
        StDiv: begin
          if (stat_i.div_last) state_q <= StFinish;
        end
        StFinish: state_q <= StOut;
        StOut: begin
          if (out_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/q32_dp.sv
// operand registers, partial product multiplier and restoring divider
`default_nettype none
module q32_dp import q32_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             round_en_i,
  input  wire logic [FuncW-1:0] func_i,
  input  wire logic [DataW-1:0] a_i,
  input  wire logic [DataW-1:0] b_i,
  input  wire q32_cmd_t         cmd_i,
  output q32_stat_t             stat_o,
  output logic [DataW-1:0]      result_o,
  output logic                  overflow_o
);
  logic [FuncW-1:0] func_q;
  logic [DataW-1:0] a_q, b_q, n_q, d_q;
  logic             round_q;
  logic [1:0]       mcnt_q;
  logic [127:0]     acc_q;
  logic [DataW-1:0] rem_q, q_q;
  logic             big_q;
  logic [StepW-1:0] step_q;
  logic [DataW-1:0] result_q;
  logic             ovf_q;

  logic a_neg, b_neg, neg, same;
  assign a_neg = a_q[DataW-1];
  assign b_neg = b_q[DataW-1];
  assign neg = a_neg ^ b_neg;
  assign same = !neg;

  assign stat_o.is_mul = (func_q == FuncMul) || (func_q == FuncSatMul);
  assign stat_o.is_div = (func_q == FuncDiv) || (func_q == FuncSatDiv);
  assign stat_o.div_zero = (b_q == '0);
  assign stat_o.div_last = (step_q == StepW'(DivSteps - 1));
  assign stat_o.mul_last = (mcnt_q == 2'd3);

  // one 32x32 partial product per step
  logic [31:0] px, py;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  always_comb begin
    px = mcnt_q[0] ? n_q[63:32] : n_q[31:0];
    py = mcnt_q[1] ? d_q[63:32] : d_q[31:0];
    pp = {32'd0, px} * {32'd0, py};
    pp_sh = {64'd0, pp} << (7'(mcnt_q[0]) * 7'd32 + 7'(mcnt_q[1]) * 7'd32);
  end

  // one restoring division step
  logic             carry, dbit, take;
  logic [DataW-1:0] rem_sh;
  logic [StepW-1:0] bitpos;
  always_comb begin
    bitpos = StepW'(DivSteps - 1) - step_q;
    carry = rem_q[DataW-1];
    dbit = (bitpos >= StepW'(33)) ? n_q[6'(bitpos - StepW'(33))] : 1'b0;
    rem_sh = {rem_q[DataW-2:0], dbit};
    take = carry || (rem_sh >= d_q);
  end

  // multiply result forming
  logic [127:0] prod, prod_r;
  logic [32:0]  top;
  logic         mul_ovf;
  always_comb begin
    prod = neg ? (~acc_q + 128'd1) : acc_q;
    prod_r = prod;
    if (round_q) begin
      prod_r = prod + {96'd0, (prod[127] ? (HalfLsb - 32'd1) : HalfLsb)};
    end
    top = prod_r[127:95];
    mul_ovf = (top != '0) && (top != '1);
  end

  // divide result forming
  logic [DataW-1:0] dmag;
  logic             div_ovf;
  always_comb begin
    dmag = {1'b0, q_q[DataW-1:1]} + ((round_q) ? {63'd0, q_q[0]} : '0);
    div_ovf = big_q || dmag[DataW-1];
  end

  // add and subtract
  logic [DataW-1:0] sum, diff;
  logic             add_ovf, sub_ovf;
  always_comb begin
    sum = a_q + b_q;
    diff = a_q - b_q;
    add_ovf = same && (a_q[DataW-1] ^ sum[DataW-1]);
    sub_ovf = !same && (a_q[DataW-1] ^ diff[DataW-1]);
  end

  // final selection
  logic [DataW-1:0] r_raw, r_fin;
  logic             o_raw;
  always_comb begin
    r_raw = sum;
    o_raw = 1'b0;
    case (func_q)
      FuncAdd, FuncSatAdd: begin
        r_raw = sum;
        o_raw = add_ovf;
      end
      FuncSub, FuncSatSub: begin
        r_raw = diff;
        o_raw = sub_ovf;
      end
      FuncMul, FuncSatMul: begin
        r_raw = prod_r[95:32];
        o_raw = mul_ovf;
      end
      default: begin
        if (b_q == '0) begin
          r_raw = OvfCode;
          o_raw = 1'b1;
        end else begin
          r_raw = neg ? (~dmag + 64'd1) : dmag;
          o_raw = div_ovf;
        end
      end
    endcase
    r_fin = r_raw;
    if (o_raw) begin
      case (func_q)
        FuncSatAdd, FuncSatSub: r_fin = a_neg ? QMin : QMax;
        FuncSatMul: r_fin = same ? QMax : QMin;
        FuncSatDiv: begin
          if (b_q == '0) r_fin = a_neg ? QMin : QMax;
          else r_fin = same ? QMax : QMin;
        end
        default: r_fin = OvfCode;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      a_q <= a_i;
      b_q <= b_i;
      n_q <= a_i[DataW-1] ? (~a_i + 64'd1) : a_i;
      d_q <= b_i[DataW-1] ? (~b_i + 64'd1) : b_i;
      round_q <= round_en_i;
      mcnt_q <= '0;
      acc_q <= '0;
      rem_q <= '0;
      q_q <= '0;
      big_q <= 1'b0;
      step_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_q + pp_sh;
      mcnt_q <= mcnt_q + 2'd1;
    end
    if (cmd_i.div_step) begin
      rem_q <= take ? (rem_sh - d_q) : rem_sh;
      if (take) begin
        if (bitpos >= StepW'(64)) big_q <= 1'b1;
        else q_q[6'(bitpos)] <= 1'b1;
      end
      step_q <= step_q + StepW'(1);
    end
    if (cmd_i.finish) begin
      result_q <= r_fin;
      ovf_q <= o_raw;
    end
  end

  assign result_o = result_q;
  assign overflow_o = ovf_q;
endmodule
`default_nettype wire

FILE: hw/rtl/q32_32_arith_unit.sv
// top level of the signed q32.32 arithmetic unit
//
// usage: one operation item enters on req (func, operand_a, operand_b) and
// one result item (result, overflow) leaves on rsp, both valid/ready.
// the unit takes one item at a time; req.ready is high only while idle.
// sequence from the accepting edge until rsp.valid rises:
//   add/sub and saturating forms: decode, finish, then output
//   multiply: decode, four 32x32 partial products (one per cycle), finish, output
//   divide: decode, 97 restoring steps (one quotient bit per cycle), finish, output
//   divide by zero: decode, finish, then output
// round_enable_i is sampled into round_enable_q when round_we_i is high;
// it resets to 1 (round to nearest, ties away from zero).
// when the receiver stalls, the result holds on rsp until taken and no
// new item is accepted.
// reset returns the sequencer to idle; operand registers are not cleared.
`default_nettype none
module q32_32_arith_unit import q32_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic round_we_i,
  input  wire logic round_enable_i,
  q32_req_if.sink   req,
  q32_rsp_if.source rsp
);
  logic      round_enable_q;
  q32_cmd_t  cmd;
  q32_stat_t stat;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_enable_q <= 1'b1;
    end else if (round_we_i) begin
      round_enable_q <= round_enable_i;
    end
  end

  q32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  q32_dp u_dp (
    .clk_i     (clk_i),
    .round_en_i(round_enable_q),
    .func_i    (req.func),
    .a_i       (req.operand_a),
    .b_i       (req.operand_b),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .result_o  (rsp.result),
    .overflow_o(rsp.overflow)
  );

  // only one command of the sequence at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul_step, cmd.div_step, cmd.finish}))
    else $error("overlapping datapath commands");

  // a load is never directly followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !rsp.valid)
    else $error("result shown right after load");

  // finish is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> rsp.valid)
    else $error("finish without result");
endmodule
`default_nettype wire

FILE: verif/q32_32_arith_unit_tb.sv
// self-checking testbench for the q32.32 arithmetic unit
`timescale 1ns / 100ps
`default_nettype none
module q32_32_arith_unit_tb;
  import q32_pkg::*;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } op_item_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic ovf;
  } res_item_t;

  // directed row: item plus optional typed-in answer
  typedef struct packed {
    op_item_t op;
    logic known;
    res_item_t res;
  } dir_row_t;

  localparam int unsigned StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic round_we_i = 1'b0;
  logic round_enable_i = 1'b1;

  q32_req_if req ();
  q32_rsp_if rsp ();

  q32_32_arith_unit i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .round_we_i(round_we_i),
    .round_enable_i(round_enable_i),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk_i = ~clk_i;

  logic round_mode = 1'b1;
  res_item_t results_due[$];
  int unsigned errors = 0;
  int unsigned n_ops = 0;
  int unsigned n_results = 0;
  int unsigned n_ovf = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    req.valid = 1'b0;
    req.func = FuncAdd;
    req.operand_a = '0;
    req.operand_b = '0;
    rsp.ready = 1'b0;
  end

  function automatic logic [DataW-1:0] magnitude(logic [DataW-1:0] v);
    return v[DataW-1] ? -v : v;
  endfunction

  // 128-bit signed product scaled back by 2^32
  function automatic logic [DataW-1:0] q_mul(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                             output logic ovf);
    logic [127:0] p;
    logic [95:0] top;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    if (a[DataW-1] ^ b[DataW-1]) p = -p;
    if (round_mode) p = p + (p[127] ? 128'h7FFF_FFFF : 128'h8000_0000);
    top = p[127:32];
    ovf = !(top[95:63] == '0 || top[95:63] == '1);
    return ovf ? OvfCode : top[63:0];
  endfunction

  // exact magnitude quotient with one extra bit for rounding
  function automatic logic [DataW-1:0] q_div(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                             output logic ovf);
    logic [127:0] q;
    logic [127:0] m;
    ovf = 1'b1;
    if (b == '0) return OvfCode;
    q = ({64'd0, magnitude(a)} << 33) / {64'd0, magnitude(b)};
    m = (q >> 1) + (round_mode ? q[0] : 1'b0);
    if (m >= 128'h8000_0000_0000_0000) return OvfCode;
    ovf = 1'b0;
    return (a[DataW-1] ^ b[DataW-1]) ? -m[63:0] : m[63:0];
  endfunction

  function automatic res_item_t arith_result(op_item_t op);
    res_item_t r;
    logic same, a_pos;
    same = op.a[DataW-1] == op.b[DataW-1];
    a_pos = !op.a[DataW-1];
    r.ovf = 1'b0;
    case (op.func)
      FuncAdd, FuncSatAdd: begin
        r.value = op.a + op.b;
        r.ovf = same && (op.a[DataW-1] != r.value[DataW-1]);
      end
      FuncSub, FuncSatSub: begin
        r.value = op.a - op.b;
        r.ovf = !same && (op.a[DataW-1] != r.value[DataW-1]);
      end
      FuncMul, FuncSatMul: r.value = q_mul(op.a, op.b, r.ovf);
      default: r.value = q_div(op.a, op.b, r.ovf);
    endcase
    if (r.ovf) begin
      case (op.func)
        FuncSatAdd, FuncSatSub: r.value = a_pos ? QMax : QMin;
        FuncSatMul: r.value = same ? QMax : QMin;
        FuncSatDiv: begin
          if (op.b == '0) r.value = a_pos ? QMax : QMin;
          else r.value = same ? QMax : QMin;
        end
        default: r.value = OvfCode;
      endcase
    end
    return r;
  endfunction

  // send one item, optional idle beforehand; valid stays up between items
  task automatic send_op(op_item_t op);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.func <= op.func;
    req.operand_a <= op.a;
    req.operand_b <= op.b;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    results_due.push_back(arith_result(op));
    n_ops++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (110) @(posedge clk_i);
  endtask

  task automatic set_round(logic v);
    round_we_i <= 1'b1;
    round_enable_i <= v;
    @(posedge clk_i);
    round_we_i <= 1'b0;
    round_mode = v;
  endtask

  // operand with bias toward edges and small magnitudes
  function automatic logic [DataW-1:0] rand_operand();
    logic [DataW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7, 0))
      0: v = v >>> $urandom_range(63, 0);
      1: v = {{32{v[40]}}, v[31:0]};
      2: v = {{40{v[63]}}, v[23:0]};
      3: v = $urandom_range(1, 0) ? QMax - $urandom_range(3, 0) : QMin + $urandom_range(3, 0);
      4: v = {v[63:32], 32'd0};
      default: ;
    endcase
    return v;
  endfunction

  function automatic op_item_t rand_op();
    op_item_t op;
    op.func = FuncW'($urandom_range(7, 0));
    op.a = rand_operand();
    op.b = ($urandom_range(40, 0) == 0) ? '0 : rand_operand();
    return op;
  endfunction

  // receiver: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t unexpected result %h ovf %b", $time, rsp.result, rsp.overflow);
        errors++;
      end else begin
        want = results_due.pop_front();
        n_results++;
        if (want.ovf) n_ovf++;
        if (rsp.result !== want.value) begin
          $display("%0t result mismatch: expected %h actual %h", $time, want.value, rsp.result);
          errors++;
        end
        if (rsp.overflow !== want.ovf) begin
          $display("%0t overflow mismatch: expected %b actual %b", $time, want.ovf,
                   rsp.overflow);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  localparam logic [DataW-1:0] One = 64'h0000_0001_0000_0000;
  localparam logic [DataW-1:0] Half = 64'h0000_0000_8000_0000;
  localparam logic [DataW-1:0] MinusOne = 64'hFFFF_FFFF_0000_0000;
  localparam logic [DataW-1:0] Lsb = 64'd1;

  dir_row_t dir_rows[] = '{
    '{'{FuncAdd, One, One}, 1'b1, '{64'h0000_0002_0000_0000, 1'b0}},
    '{'{FuncAdd, QMax, Lsb}, 1'b1, '{OvfCode, 1'b1}},
    '{'{FuncSatAdd, QMax, Lsb}, 1'b1, '{QMax, 1'b1}},
    '{'{FuncSatAdd, QMin, QMin}, 1'b1, '{QMin, 1'b1}},
    '{'{FuncSub, QMin, Lsb}, 1'b1, '{OvfCode, 1'b1}},
    '{'{FuncSatSub, QMin, Lsb}, 1'b1, '{QMin, 1'b1}},
    '{'{FuncSatSub, 64'd0, QMin}, 1'b1, '{QMax, 1'b1}},
    '{'{FuncSub, QMax, QMax}, 1'b1, '{64'd0, 1'b0}},
    '{'{FuncMul, One, MinusOne}, 1'b1, '{MinusOne, 1'b0}},
    '{'{FuncMul, QMax, QMax}, 1'b1, '{OvfCode, 1'b1}},
    '{'{FuncSatMul, QMax, QMin}, 1'b1, '{QMin, 1'b1}},
    '{'{FuncSatMul, QMin, QMin}, 1'b1, '{QMax, 1'b1}},
    '{'{FuncMul, Lsb, Half}, 1'b0, '0},
    '{'{FuncMul, -Lsb, Half}, 1'b0, '0},
    '{'{FuncMul, QMin, One}, 1'b1, '{QMin, 1'b0}},
    '{'{FuncDiv, One, 64'd0}, 1'b1, '{OvfCode, 1'b1}},
    '{'{FuncSatDiv, MinusOne, 64'd0}, 1'b1, '{QMin, 1'b1}},
    '{'{FuncSatDiv, 64'd0, 64'd0}, 1'b1, '{QMax, 1'b1}},
    '{'{FuncDiv, One, 64'h0000_0003_0000_0000}, 1'b0, '0},
    '{'{FuncDiv, Lsb, 64'h0000_0002_0000_0000}, 1'b0, '0},
    '{'{FuncDiv, QMin, MinusOne}, 1'b1, '{OvfCode, 1'b1}},
    '{'{FuncSatDiv, QMin, Lsb}, 1'b1, '{QMin, 1'b1}},
    '{'{FuncDiv, QMin, QMin}, 1'b1, '{One, 1'b0}},
    '{'{FuncSatDiv, QMax, -Lsb}, 1'b1, '{QMin, 1'b1}}
  };

  // main sequence
  initial begin
    res_item_t want;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, rounding on then off
    for (int pass = 0; pass < 2; pass++) begin
      foreach (dir_rows[i]) begin
        if (dir_rows[i].known && pass == 0) begin
          want = arith_result(dir_rows[i].op);
          if (want !== dir_rows[i].res) begin
            $display("%0t row %0d: expected %h/%b predictor %h/%b", $time, i,
                     dir_rows[i].res.value, dir_rows[i].res.ovf, want.value, want.ovf);
            errors++;
          end
        end
        send_op(dir_rows[i].op);
      end
      drain();
      set_round(1'b0);
    end

    // random phases over idling mixes and round settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 47; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 47; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      set_round(ph[0] ^ ph[2]);
      if (ph == 2) hold_cycles = 400;
      for (int k = 0; k < 150; k++) send_op(rand_op());
      drain();
    end

    $display("run covered %0d operations, %0d results, %0d with overflow,", n_ops, n_results,
             n_ovf);
    $display("both round settings and four idling mixes including a long receiver hold-off");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/q32_pkg.sv
hw/rtl/q32_if.sv
hw/rtl/q32_ctrl.sv
hw/rtl/q32_dp.sv
hw/rtl/q32_32_arith_unit.sv
verif/q32_32_arith_unit_tb.sv
